// ----- src/rpq_pkg.sv -----
package rpq_pkg;

    localparam int COUNT_BITS = 17;
    localparam int OUT_BITS   = 17;
    localparam int BASE_BITS  = (COUNT_BITS > 17) ? COUNT_BITS : 17;
    localparam int SUM_BITS   = BASE_BITS + 3;
    localparam int SHARE_BITS = 16;

    localparam logic signed [COUNT_BITS-1:0] CNT_LO = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_HI = {1'b0, {(COUNT_BITS-1){1'b1}}};

    typedef enum logic [2:0] {
        REQ_CHECK   = 3'd0,
        REQ_CONSUME = 3'd1,
        REQ_REFILL  = 3'd2,
        REQ_REPART  = 3'd3,
        REQ_LOAD    = 3'd4
    } t_req_type;

    typedef enum logic [1:0] {
        CAT_TITLE   = 2'd0,
        CAT_MARKET  = 2'd1,
        CAT_PROFILE = 2'd2,
        CAT_POOL    = 2'd3
    } t_category;

    typedef enum logic [2:0] {
        CFG_HOURLY_MAX    = 3'd0,
        CFG_MARKET_SHARE  = 3'd1,
        CFG_PROFILE_SHARE = 3'd2,
        CFG_TITLE_SHARE   = 3'd3,
        CFG_AUTO_BORROW   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  category;
        logic [15:0] load_value;
    } t_req;

    typedef struct packed {
        logic [15:0]           hourly_max;
        logic [SHARE_BITS-1:0] market_share;
        logic [SHARE_BITS-1:0] profile_share;
        logic [SHARE_BITS-1:0] title_share;
        logic                  auto_borrow;
    } t_cfg;

    typedef struct packed {
        logic signed [COUNT_BITS-1:0] title;
        logic signed [COUNT_BITS-1:0] market;
        logic signed [COUNT_BITS-1:0] profile;
        logic signed [COUNT_BITS-1:0] pool;
    } t_split;

    function automatic logic signed [COUNT_BITS-1:0] clamp_cnt(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] lo_w;
        logic signed [SUM_BITS-1:0] hi_w;
        lo_w = SUM_BITS'(CNT_LO);
        hi_w = SUM_BITS'(CNT_HI);
        if (v < lo_w) begin
            return CNT_LO;
        end else if (v > hi_w) begin
            return CNT_HI;
        end
        return v[COUNT_BITS-1:0];
    endfunction

    function automatic logic signed [COUNT_BITS-1:0] dec_sat(
        input logic signed [COUNT_BITS-1:0] v
    );
        return (v == CNT_LO) ? CNT_LO : v - COUNT_BITS'(1);
    endfunction

    function automatic logic is_pos(input logic signed [COUNT_BITS-1:0] v);
        return !v[COUNT_BITS-1] && (v != '0);
    endfunction

    function automatic logic [OUT_BITS-1:0] to_out(
        input logic signed [COUNT_BITS-1:0] v
    );
        logic signed [63:0] w;
        w = 64'(v);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

// ----- src/rpq_in_reg.sv -----
module rpq_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rpq_pkg::t_req      i_req,
    input  logic               i_take,
    output logic               o_valid,
    output rpq_pkg::t_req      o_req
);

    logic          r_valid;
    rpq_pkg::t_req r_req;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

// ----- src/rpq_split.sv -----
module rpq_split (
    input  logic signed [rpq_pkg::BASE_BITS-1:0] i_base,
    input  rpq_pkg::t_cfg                        i_cfg,
    output rpq_pkg::t_split                      o_split
);

    localparam int BW = rpq_pkg::BASE_BITS;
    localparam int SW = rpq_pkg::SUM_BITS;
    localparam int PW = rpq_pkg::BASE_BITS + rpq_pkg::SHARE_BITS;

    function automatic logic signed [SW-1:0] share_of(
        input logic signed [BW-1:0]                 base,
        input logic [rpq_pkg::SHARE_BITS-1:0]       share
    );
        logic [BW-1:0]          mag;
        logic [PW-1:0]          prod;
        logic signed [SW-1:0]   part;
        mag  = base[BW-1] ? BW'(-base) : BW'(base);
        prod = PW'(mag) * PW'(share);
        part = SW'(prod[PW-1:rpq_pkg::SHARE_BITS]);
        return base[BW-1] ? -part : part;
    endfunction

    logic signed [SW-1:0] w_base;
    logic signed [SW-1:0] w_market;
    logic signed [SW-1:0] w_profile;
    logic signed [SW-1:0] w_title;
    logic signed [SW-1:0] w_pool;

    assign w_base    = SW'(i_base);
    assign w_market  = share_of(i_base, i_cfg.market_share);
    assign w_profile = share_of(i_base, i_cfg.profile_share);
    assign w_title   = share_of(i_base, i_cfg.title_share);
    assign w_pool    = w_base - w_market - w_profile - w_title;

    assign o_split.market  = rpq_pkg::clamp_cnt(w_market);
    assign o_split.profile = rpq_pkg::clamp_cnt(w_profile);
    assign o_split.title   = rpq_pkg::clamp_cnt(w_title);
    assign o_split.pool    = rpq_pkg::clamp_cnt(w_pool);

endmodule

// ----- src/partitioned_request_quota.sv -----
// An accepted transaction is captured in the input register and then in the result
// register, which takes it only when no result is held or the held one is being taken.
// Throughput: one transaction per cycle unless the output stalls; the credit update runs
// combinationally through three 16-bit share multipliers from input to result register.
// Reset (synchronous, active low) clears all credits, configuration and valid flags.
module partitioned_request_quota (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [2:0]                        i_req_type,
    input  logic [1:0]                        i_category,
    input  logic [15:0]                       i_load_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_granted,
    output logic signed [rpq_pkg::OUT_BITS-1:0] o_category_left,
    output logic signed [rpq_pkg::OUT_BITS-1:0] o_total_left,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    localparam int C  = rpq_pkg::COUNT_BITS;
    localparam int BW = rpq_pkg::BASE_BITS;
    localparam int SW = rpq_pkg::SUM_BITS;

    rpq_pkg::t_cfg   r_cfg;
    rpq_pkg::t_req   w_in_req;
    rpq_pkg::t_req   w_req;
    rpq_pkg::t_split w_split;
    logic            w_req_valid;
    logic            w_advance;

    logic signed [C-1:0]  r_total, r_title, r_market, r_profile, r_pool;
    logic signed [C-1:0]  n_total, n_title, n_market, n_profile, n_pool;
    logic signed [C-1:0]  w_cat_now;
    logic signed [C-1:0]  n_cat_left;
    logic signed [BW-1:0] w_base;
    logic                 w_grant;

    logic                             r_out_valid;
    logic                             r_granted;
    logic [rpq_pkg::OUT_BITS-1:0]     r_cat_left;
    logic [rpq_pkg::OUT_BITS-1:0]     r_total_left;

    assign w_in_req.req_type   = i_req_type;
    assign w_in_req.category   = i_category;
    assign w_in_req.load_value = i_load_value;

    assign w_advance = w_req_valid && (!r_out_valid || i_out_ready);

    rpq_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (w_in_req),
        .i_take  (w_advance),
        .o_valid (w_req_valid),
        .o_req   (w_req)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rpq_pkg::CFG_HOURLY_MAX:    r_cfg.hourly_max    <= i_cfg_data;
                rpq_pkg::CFG_MARKET_SHARE:  r_cfg.market_share  <= i_cfg_data;
                rpq_pkg::CFG_PROFILE_SHARE: r_cfg.profile_share <= i_cfg_data;
                rpq_pkg::CFG_TITLE_SHARE:   r_cfg.title_share   <= i_cfg_data;
                rpq_pkg::CFG_AUTO_BORROW:   r_cfg.auto_borrow   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_base = (w_req.req_type == rpq_pkg::REQ_REPART) ? BW'(r_total)
                                                            : BW'(r_cfg.hourly_max);

    rpq_split u_split (
        .i_base  (w_base),
        .i_cfg   (r_cfg),
        .o_split (w_split)
    );

    always_comb begin
        unique case (w_req.category)
            rpq_pkg::CAT_TITLE:   w_cat_now = r_title;
            rpq_pkg::CAT_MARKET:  w_cat_now = r_market;
            rpq_pkg::CAT_PROFILE: w_cat_now = r_profile;
            default:              w_cat_now = r_pool;
        endcase
    end

    assign w_grant = rpq_pkg::is_pos(r_total) &&
                     (rpq_pkg::is_pos(w_cat_now) ||
                      (r_cfg.auto_borrow && rpq_pkg::is_pos(r_pool)));

    always_comb begin
        n_total   = r_total;
        n_title   = r_title;
        n_market  = r_market;
        n_profile = r_profile;
        n_pool    = r_pool;
        unique case (w_req.req_type)
            rpq_pkg::REQ_CONSUME: begin
                n_total = rpq_pkg::dec_sat(r_total);
                if (!rpq_pkg::is_pos(w_cat_now) || w_req.category == rpq_pkg::CAT_POOL) begin
                    n_pool = rpq_pkg::dec_sat(r_pool);
                end
                unique case (w_req.category)
                    rpq_pkg::CAT_TITLE:   n_title   = rpq_pkg::dec_sat(r_title);
                    rpq_pkg::CAT_MARKET:  n_market  = rpq_pkg::dec_sat(r_market);
                    rpq_pkg::CAT_PROFILE: n_profile = rpq_pkg::dec_sat(r_profile);
                    default: ;
                endcase
            end
            rpq_pkg::REQ_REFILL, rpq_pkg::REQ_REPART: begin
                n_title   = w_split.title;
                n_market  = w_split.market;
                n_profile = w_split.profile;
                n_pool    = w_split.pool;
            end
            rpq_pkg::REQ_LOAD: begin
                n_total = rpq_pkg::clamp_cnt(SW'(w_req.load_value));
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (w_req.category)
            rpq_pkg::CAT_TITLE:   n_cat_left = n_title;
            rpq_pkg::CAT_MARKET:  n_cat_left = n_market;
            rpq_pkg::CAT_PROFILE: n_cat_left = n_profile;
            default:              n_cat_left = n_pool;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_title   <= '0;
            r_market  <= '0;
            r_profile <= '0;
            r_pool    <= '0;
        end else if (w_advance) begin
            r_total   <= n_total;
            r_title   <= n_title;
            r_market  <= n_market;
            r_profile <= n_profile;
            r_pool    <= n_pool;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_granted    <= w_grant;
            r_cat_left   <= rpq_pkg::to_out(n_cat_left);
            r_total_left <= rpq_pkg::to_out(n_total);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted       = r_granted;
    assign o_category_left = r_cat_left;
    assign o_total_left    = r_total_left;

    a_hold_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_total) && $stable(r_pool))
        else $error("Credits changed while a result transaction was stalled.");

    a_total_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_total_left == rpq_pkg::to_out(r_total))
        else $error("Reported total does not match the total credit.");

    a_in_capture : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> w_req_valid)
        else $error("Accepted transaction was not held in the input register.");

    a_check_no_update : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_req.req_type == rpq_pkg::REQ_CHECK
        |=> $stable(r_total) && $stable(r_pool) && $stable(r_title))
        else $error("A check transaction modified the credits.");

endmodule
